// File: rtl/multistrike_payoff_greek_accumulator_assert.svh
// assertion macros for the greek accumulator
// used by the top level; no other dependencies
`ifndef MULTISTRIKE_PAYOFF_GREEK_ACCUMULATOR_ASSERT_SVH
`define MULTISTRIKE_PAYOFF_GREEK_ACCUMULATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MPGA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error("lbl");
`define MPGA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("lbl");
`else
`define MPGA_ASSERT(lbl, prop)
`define MPGA_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/mpga_pkg.sv
// constants, types and rounding helpers for the greek accumulator
// no dependencies
`default_nettype none
package mpga_pkg;
    localparam int MAX_STRIKES = 16;
    localparam int FRAC_BITS = 16;
    localparam int TABLE_DEPTH = (MAX_STRIKES < 16) ? MAX_STRIKES : 16;
    localparam int FIELDS = 4;
    localparam int IDX_W = 4;
    localparam int SUM_ADDR_W = 6;
    localparam logic [47:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ACC = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] REG_DISCOUNT = 2'd0;
    localparam logic [1:0] REG_MATURITY = 2'd1;
    localparam logic [1:0] REG_CV = 2'd2;
    localparam logic [1:0] REG_ACTIVE = 2'd3;

    // product magnitude rounded to nearest, ties away, sign restored
    function automatic logic signed [63:0] round_q(input logic neg, input logic [79:0] mag);
        logic [79:0] r;
        r = (mag + 80'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return neg ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction
endpackage
`default_nettype wire

// File: rtl/mpga_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module mpga_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/multistrike_payoff_greek_accumulator.sv
// Multi-strike Monte Carlo payoff and greek accumulator. The opcode of an item
// travels on s_tuser and the strike number of a result on m_tuser. An accumulate
// item walks the active strikes one after another; for each it does the strike
// read and payoff, the payoff and three discount products, the price, the rho
// correction, then four read-modify-write passes on the sums ram, reads on odd
// steps and writes on even ones. The block takes no new item until the last
// active strike is done. A read item sends one result per active strike; each
// result fetches the four sums from the ram and is then held while m_tready
// stays low. After reset, and after each clear item, a clearing pass writes
// zero to the 64 sums, with no item taken. A load item writes the strike table
// without leaving the idle state.
// Needs mpga_pkg, mpga_ram and the assertion header.
`default_nettype none
`include "multistrike_payoff_greek_accumulator_assert.svh"
module multistrike_payoff_greek_accumulator
    import mpga_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [22:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode
    input  wire logic [1:0]   s_tuser,
    // strike_index, strike_price, call_flag, arith_avg, arith_delta, arith_vega,
    // arith_rho, geo_avg, geo_delta, geo_vega, geo_rho; 4 pad bits
    input  wire logic [295:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_strike
    output logic [3:0]        m_tuser,
    // price_sum, delta_sum, vega_sum, rho_sum, paths_done
    output logic [303:0]      m_tdata,
    output logic              m_tlast
);
    localparam logic [2:0] ST_CLR = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_ACC = 3'd2;
    localparam logic [2:0] ST_RD = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0]  st_reg;
    logic [16:0] disc_reg;
    logic [22:0] mat_reg;
    logic        cv_reg;
    logic [4:0]  act_reg;
    logic [47:0] cnt_reg;
    logic [5:0]  clr_reg;

    // input fields
    logic [1:0]  in_op;
    logic [3:0]  in_idx;
    logic [30:0] in_k;
    logic        in_call;
    assign in_op = s_tuser;
    assign in_idx = s_tdata[3:0];
    assign in_k = s_tdata[34:4];
    assign in_call = s_tdata[35];

    // captured path
    logic signed [31:0] a_reg, g_reg;
    logic signed [31:0] ab_reg [3];
    logic signed [31:0] gb_reg [3];

    logic [30:0] ktab [TABLE_DEPTH];
    logic        stab [TABLE_DEPTH];

    logic [4:0] n_act;
    always_comb begin
        n_act = act_reg;
        if (n_act == 5'd0) n_act = 5'd1;
        if (n_act > 5'(TABLE_DEPTH)) n_act = 5'(TABLE_DEPTH);
    end

    // per strike sequencing: step 0 payoff, 1 products, 2 price, 3 rho,
    // sums read on steps 3, 5, 7, 9 and written back on steps 4, 6, 8, 10
    logic [3:0]  stk_reg;
    logic [3:0]  step_reg;
    logic signed [33:0] ap_reg, gp_reg;
    logic        ai_reg, gi_reg;
    logic signed [63:0] add_reg [4];
    logic signed [63:0] ar_reg, gr_reg;
    logic signed [63:0] sums_reg [4];

    // ram
    logic        we;
    logic [5:0]  waddr, raddr;
    logic [63:0] wdata, rdata;
    mpga_ram #(.WIDTH(64), .DEPTH(64)) u_sums (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [1:0] fld;
    assign fld = step_reg[2:1] - 2'd1;
    assign raddr = {stk_reg, (st_reg == ST_RD) ? step_reg[1:0] : fld};

    // products for price: magnitude times discount
    logic signed [33:0] ap_g, gp_g;
    logic [33:0] ap_m, gp_m;
    assign ap_g = ai_reg ? ap_reg : 34'sd0;
    assign gp_g = gi_reg ? gp_reg : 34'sd0;
    assign ap_m = ap_g[33] ? 34'(-ap_g) : 34'(ap_g);
    assign gp_m = gp_g[33] ? 34'(-gp_g) : 34'(gp_g);

    logic signed [33:0] gv [3];
    logic [33:0] gv_m [3];
    always_comb begin
        for (int f = 0; f < 3; f++) begin
            logic signed [33:0] av, gg;
            av = ai_reg ? (stab[stk_reg] ? 34'(ab_reg[f]) : -34'(ab_reg[f])) : 34'sd0;
            gg = gi_reg ? (stab[stk_reg] ? 34'(gb_reg[f]) : -34'(gb_reg[f])) : 34'sd0;
            gv[f] = av - gg;
            gv_m[f] = gv[f][33] ? 34'(-gv[f]) : 34'(gv[f]);
        end
    end

    logic [63:0] pr_m;
    assign pr_m = add_reg[0][63] ? 64'(-add_reg[0]) : 64'(add_reg[0]);
    logic signed [63:0] rho_corr;
    // price magnitude stays below 2^44 so 44 x 23 product fits
    assign rho_corr = round_q(add_reg[0][63],
                              {13'd0, {23'd0, pr_m[43:0]} * {44'd0, mat_reg}});

    logic [1:0] rmw_f;
    assign rmw_f = step_reg[2:1] - 2'd2;
    assign we = (st_reg == ST_CLR) || (st_reg == ST_ACC && step_reg >= 4'd4 && !step_reg[0]);
    assign waddr = (st_reg == ST_CLR) ? clr_reg : {stk_reg, rmw_f};
    assign wdata = (st_reg == ST_CLR) ? 64'd0 : sat_add(rdata, add_reg[rmw_f]);

    assign s_tready = (st_reg == ST_IDLE);
    logic acc;
    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            disc_reg <= 17'd65536;
            mat_reg <= 23'd65536;
            cv_reg <= 1'b0;
            act_reg <= 5'd1;
            cnt_reg <= '0;
            m_tvalid <= 1'b0;
            stk_reg <= '0;
            step_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DISCOUNT: disc_reg <= cfg_data[16:0];
                    REG_MATURITY: mat_reg <= cfg_data;
                    REG_CV:       cv_reg <= cfg_data[0];
                    REG_ACTIVE:   act_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            unique case (st_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 6'd1;
                    if (clr_reg == 6'd63) st_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (acc) begin
                        stk_reg <= '0;
                        step_reg <= '0;
                        unique case (in_op)
                            OP_LOAD: begin
                                if (32'(in_idx) < TABLE_DEPTH) begin
                                    ktab[in_idx[IDX_W-1:0]] <= in_k;
                                    stab[in_idx[IDX_W-1:0]] <= in_call;
                                end
                            end
                            OP_CLEAR: begin
                                cnt_reg <= '0;
                                clr_reg <= '0;
                                st_reg <= ST_CLR;
                            end
                            OP_ACC: begin
                                a_reg <= s_tdata[67:36];
                                ab_reg[0] <= s_tdata[99:68];
                                ab_reg[1] <= s_tdata[131:100];
                                ab_reg[2] <= s_tdata[163:132];
                                g_reg <= s_tdata[195:164];
                                gb_reg[0] <= s_tdata[227:196];
                                gb_reg[1] <= s_tdata[259:228];
                                gb_reg[2] <= s_tdata[291:260];
                                st_reg <= ST_ACC;
                            end
                            OP_READ: st_reg <= ST_RD;
                            default: ;
                        endcase
                    end
                end
                ST_ACC: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd0: begin
                            logic signed [33:0] k, a2, g2;
                            k = 34'(ktab[stk_reg]);
                            a2 = 34'(a_reg);
                            g2 = 34'(g_reg);
                            ap_reg <= stab[stk_reg] ? a2 - k : k - a2;
                            gp_reg <= stab[stk_reg] ? g2 - k : k - g2;
                            ai_reg <= stab[stk_reg] ? (a2 > k) : (k > a2);
                            gi_reg <= cv_reg && (stab[stk_reg] ? (g2 > k) : (k > g2));
                        end
                        4'd1: begin
                            ar_reg <= round_q(1'b0,
                                              {29'd0, {17'd0, ap_m} * {34'd0, disc_reg}});
                            gr_reg <= round_q(1'b0,
                                              {29'd0, {17'd0, gp_m} * {34'd0, disc_reg}});
                            for (int f = 0; f < 3; f++)
                                add_reg[f+1] <= round_q(gv[f][33],
                                    {29'd0, {17'd0, gv_m[f]} * {34'd0, disc_reg}});
                        end
                        4'd2: add_reg[0] <= ar_reg - gr_reg;
                        4'd3: add_reg[3] <= add_reg[3] - rho_corr;
                        4'd10: begin
                            step_reg <= '0;
                            stk_reg <= stk_reg + 4'd1;
                            if (5'(stk_reg) + 5'd1 == n_act) begin
                                st_reg <= ST_IDLE;
                                if (cnt_reg != COUNT_MAX) cnt_reg <= cnt_reg + 48'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_RD: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg >= 4'd1) sums_reg[step_reg[1:0] - 2'd1] <= rdata;
                    if (step_reg == 4'd4) begin
                        m_tvalid <= 1'b1;
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        step_reg <= '0;
                        stk_reg <= stk_reg + 4'd1;
                        st_reg <= m_tlast ? ST_IDLE : ST_RD;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tlast = (5'(stk_reg) + 5'd1 == n_act);
    assign m_tuser = stk_reg;
    assign m_tdata = {cnt_reg, sums_reg[3], sums_reg[2], sums_reg[1], sums_reg[0]};

    `MPGA_ASSERT(a_out_only_in_out, m_tvalid |-> st_reg == ST_OUT)
    `MPGA_ASSERT(a_no_take_busy, (st_reg != ST_IDLE) |-> !s_tready)
    `MPGA_ASSERT(a_cnt_sat, (cnt_reg == COUNT_MAX) |=> (cnt_reg == COUNT_MAX || cnt_reg == 48'd0))
    `MPGA_ASSERT_RST(a_rst_clr, !aresetn |=> st_reg == ST_CLR && !m_tvalid)
endmodule
`default_nettype wire

// File: test/tb.sv
// testbench for multistrike_payoff_greek_accumulator: strike loads, clears,
// path accumulation and sum readouts checked against an in-bench predictor
// depends on mpga_pkg and the accumulator rtl
`timescale 1ns / 1ps
module tb;
    import mpga_pkg::*;

    typedef struct {
        logic [1:0]         opcode;
        logic [3:0]         strike_index;
        logic [30:0]        strike_price;
        logic               call_flag;
        logic signed [31:0] a_avg, a_delta, a_vega, a_rho;
        logic signed [31:0] g_avg, g_delta, g_vega, g_rho;
    } path_item_t;

    typedef struct {
        logic [3:0]         strike;
        logic signed [63:0] sums [4];
        logic [47:0]        paths;
        logic               last;
    } sums_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [22:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [295:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [3:0]   m_tuser;
    logic [303:0] m_tdata;
    logic         m_tlast;

    multistrike_payoff_greek_accumulator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // predictor state
    logic [30:0]        strikes [16];
    logic               is_call [16];
    logic signed [63:0] greek_acc [16][4];
    logic [47:0]        path_cnt;
    logic [16:0]        disc_q;
    logic [22:0]        mat_q;
    logic               cv_on;
    logic [4:0]         n_active;

    path_item_t pending_items [$];
    sums_out_t  expected_sums [$];
    path_item_t cur_item;
    int unsigned send_gap = 0, recv_stall = 0;
    int unsigned n_results = 0, n_mismatch = 0, n_acc = 0, n_reads = 0;

    initial forever #5 aclk = ~aclk;

    function automatic logic [295:0] pack_item(input path_item_t it);
        return {4'b0000, it.g_rho, it.g_vega, it.g_delta, it.g_avg,
                it.a_rho, it.a_vega, it.a_delta, it.a_avg,
                it.call_flag, it.strike_price, it.strike_index};
    endfunction

    // (x * m) >> 16, rounded to nearest with ties away from zero
    function automatic logic signed [63:0] scale_q16(input logic signed [63:0] x,
                                                     input logic [22:0] m);
        logic          neg;
        logic [63:0]   mag;
        logic [127:0]  prod;
        neg = x < 0;
        mag = neg ? -x : x;
        prod = ({64'd0, mag} * {105'd0, m} + 128'd32768) >> FRAC_BITS;
        return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000
                                         : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic int strikes_in_use();
        if (n_active == 0) return 1;
        if (n_active > 16) return 16;
        return n_active;
    endfunction

    task automatic apply_item(input path_item_t it);
        logic signed [63:0] a, g, k, ap, gp, price, av, gv;
        logic signed [63:0] ab [3], gb [3], delta_add [4];
        logic               ai, gi, call;
        sums_out_t          r;
        int                 n;
        n = strikes_in_use();
        case (it.opcode)
            OP_LOAD: begin
                strikes[it.strike_index] = it.strike_price;
                is_call[it.strike_index] = it.call_flag;
            end
            OP_CLEAR: begin
                for (int i = 0; i < 16; i++)
                    for (int f = 0; f < 4; f++) greek_acc[i][f] = '0;
                path_cnt = '0;
            end
            OP_ACC: begin
                a = it.a_avg; g = it.g_avg;
                ab[0] = it.a_delta; ab[1] = it.a_vega; ab[2] = it.a_rho;
                gb[0] = it.g_delta; gb[1] = it.g_vega; gb[2] = it.g_rho;
                for (int i = 0; i < n; i++) begin
                    call = is_call[i];
                    k = {33'd0, strikes[i]};
                    ap = call ? a - k : k - a;
                    gp = call ? g - k : k - g;
                    ai = ap > 0;
                    gi = cv_on && gp > 0;
                    price = scale_q16(ai ? ap : 64'sd0, disc_q)
                          - scale_q16(gi ? gp : 64'sd0, disc_q);
                    delta_add[0] = price;
                    for (int f = 0; f < 3; f++) begin
                        av = ai ? (call ? ab[f] : -ab[f]) : 64'sd0;
                        gv = gi ? (call ? gb[f] : -gb[f]) : 64'sd0;
                        delta_add[f + 1] = scale_q16(av - gv, disc_q);
                    end
                    delta_add[3] = delta_add[3] - scale_q16(price, mat_q);
                    for (int f = 0; f < 4; f++)
                        greek_acc[i][f] = clamp_add(greek_acc[i][f], delta_add[f]);
                end
                if (path_cnt != COUNT_MAX) path_cnt = path_cnt + 1;
                n_acc++;
            end
            OP_READ: begin
                for (int i = 0; i < n; i++) begin
                    r.strike = i[3:0];
                    for (int f = 0; f < 4; f++) r.sums[f] = greek_acc[i][f];
                    r.paths = path_cnt;
                    r.last = (i == n - 1);
                    expected_sums.push_back(r);
                end
                n_reads++;
            end
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            apply_item(cur_item);
            send_gap = $urandom_range(0, 3);
            if (send_gap == 0 && pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_tuser <= cur_item.opcode;
                s_tdata <= pack_item(cur_item);
            end else begin
                s_tvalid <= 1'b0;
            end
        end else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_tuser <= cur_item.opcode;
                s_tdata <= pack_item(cur_item);
                s_tvalid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sums_out_t e;
        logic      bad;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_sums.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result %h %h", m_tuser, m_tdata);
                end else begin
                    e = expected_sums.pop_front();
                    bad = m_tuser !== e.strike || m_tdata[63:0] !== e.sums[0]
                       || m_tdata[127:64] !== e.sums[1] || m_tdata[191:128] !== e.sums[2]
                       || m_tdata[255:192] !== e.sums[3] || m_tdata[303:256] !== e.paths
                       || m_tlast !== e.last;
                    if (bad) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("mismatch: exp strike %0d sums %0d %0d %0d %0d paths %0d last %0b",
                                     e.strike, e.sums[0], e.sums[1], e.sums[2], e.sums[3],
                                     e.paths, e.last);
                            $display("          got strike %0d sums %0d %0d %0d %0d paths %0d last %0b",
                                     m_tuser, $signed(m_tdata[63:0]),
                                     $signed(m_tdata[127:64]), $signed(m_tdata[191:128]),
                                     $signed(m_tdata[255:192]), m_tdata[303:256], m_tlast);
                        end
                    end
                end
                recv_stall = $urandom_range(0, 3);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_sums.size() > 0)
            @(posedge aclk);
        // accumulate and clear give no result, so let the pipeline drain
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_config(input logic [16:0] d, input logic [22:0] m,
                              input logic cv, input logic [4:0] act);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= REG_DISCOUNT; cfg_data <= {6'd0, d}; disc_q = d;
        @(posedge aclk);
        cfg_index <= REG_MATURITY; cfg_data <= m; mat_q = m;
        @(posedge aclk);
        cfg_index <= REG_CV; cfg_data <= {22'd0, cv}; cv_on = cv;
        @(posedge aclk);
        cfg_index <= REG_ACTIVE; cfg_data <= {18'd0, act}; n_active = act;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic path_item_t make_path(input logic [1:0] op);
        path_item_t it;
        logic       wide;
        it.opcode = op;
        it.strike_index = 4'($urandom_range(0, 15));
        it.strike_price = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(1, 32'h7FFF_FFFF))
                                                      : 31'($urandom_range(32'h50_0000,
                                                                           32'h78_0000));
        it.call_flag = 1'($urandom_range(0, 1));
        wide = $urandom_range(0, 4) == 0;
        // most paths sit near the strikes so payoffs land both sides of zero
        it.a_avg = wide ? $urandom() : $urandom_range(32'h40_0000, 32'h88_0000);
        it.g_avg = wide ? $urandom() : it.a_avg - $urandom_range(0, 32'h8_0000);
        it.a_delta = $urandom(); it.a_vega = $urandom(); it.a_rho = $urandom();
        it.g_delta = $urandom(); it.g_vega = $urandom(); it.g_rho = $urandom();
        if (!wide) begin
            it.a_delta = $signed(it.a_delta) >>> 12; it.g_delta = $signed(it.g_delta) >>> 12;
        end
        return it;
    endfunction

    function automatic logic [1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return OP_ACC;
        if (r < 78) return OP_READ;
        if (r < 83) return OP_CLEAR;
        return OP_LOAD;
    endfunction

    initial begin
        path_item_t it;
        path_cnt = '0;
        for (int i = 0; i < 16; i++) for (int f = 0; f < 4; f++) greek_acc[i][f] = '0;
        disc_q = 17'd65536; mat_q = 23'd65536; cv_on = 1'b0; n_active = 5'd1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_config(17'd65536, 23'd6553600, 1'b1, 5'd16);

        // every strike entry written first, with the price extremes
        for (int i = 0; i < 16; i++) begin
            it = make_path(OP_LOAD);
            it.strike_index = 4'(i);
            it.call_flag = i[0];
            if (i == 0) it.strike_price = 31'd1;
            if (i == 1) it.strike_price = 31'h7FFF_FFFF;
            pending_items.push_back(it);
        end
        it = make_path(OP_ACC);
        it.a_avg = 32'sh7FFF_FFFF; it.g_avg = 32'sh8000_0000;
        it.a_delta = 32'sh8000_0000; it.a_vega = 32'sh7FFF_FFFF;
        pending_items.push_back(it);
        it.a_avg = 32'sh8000_0000; it.g_avg = 32'sh7FFF_FFFF;
        pending_items.push_back(it);
        it = make_path(OP_ACC);
        it.a_avg = '0; it.g_avg = '0;
        pending_items.push_back(it);
        pending_items.push_back(make_path(OP_READ));
        pending_items.push_back(make_path(OP_CLEAR));
        pending_items.push_back(make_path(OP_ACC));
        pending_items.push_back(make_path(OP_READ));
        wait_idle();

        // configuration sweep, including active counts out of range
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(17'd65536, 23'd65536, 1'b0, 5'd1);
                1: set_config(17'd0, 23'd0, 1'b1, 5'd16);
                2: set_config(17'd65536, 23'd6553600, 1'b1, 5'd0);
                3: set_config(17'($urandom_range(0, 65536)), 23'($urandom_range(0, 6553600)),
                              1'b0, 5'd31);
                4: set_config(17'($urandom_range(0, 65536)), 23'($urandom_range(0, 6553600)),
                              1'b1, 5'($urandom_range(1, 16)));
                default: set_config(17'd1, 23'd1, 1'b0, 5'd17);
            endcase
            for (int j = 0; j < 25; j++) pending_items.push_back(make_path(pick_op()));
            pending_items.push_back(make_path(OP_READ));
            wait_idle();
        end

        $display("ran %0d paths and %0d readouts, %0d results checked, %0d mismatches",
                 n_acc, n_reads, n_results, n_mismatch);
        if (n_mismatch == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
